// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the address decoder checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TWAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("decoder check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define TWAD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("decoder check failed");

`endif

// ===== design/twad_pkg.sv =====
// ----------------------------------------------------------------------------
// twad_pkg
// Codes and defaults shared by the TCM window address decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package twad_pkg;

	localparam int unsigned ITCM_BYTES_DFLT     = 32768;
	localparam int unsigned DTCM_BYTES_DFLT     = 16384;
	localparam int unsigned MAIN_RAM_BYTES_DFLT = 4194304;

	localparam int unsigned PADDR_W = 5;

	typedef logic [3:0] tgt_t;
	localparam tgt_t TGT_ITCM  = 4'd0;
	localparam tgt_t TGT_DTCM  = 4'd1;
	localparam tgt_t TGT_MAIN  = 4'd2;
	localparam tgt_t TGT_SWRAM = 4'd3;
	localparam tgt_t TGT_IO    = 4'd4;
	localparam tgt_t TGT_PAL   = 4'd5;
	localparam tgt_t TGT_BGA   = 4'd6;
	localparam tgt_t TGT_BGB   = 4'd7;
	localparam tgt_t TGT_OBJA  = 4'd8;
	localparam tgt_t TGT_OBJB  = 4'd9;
	localparam tgt_t TGT_LCDC  = 4'd10;
	localparam tgt_t TGT_OAM   = 4'd11;
	localparam tgt_t TGT_CART  = 4'd12;
	localparam tgt_t TGT_BIOS  = 4'd13;
	localparam tgt_t TGT_NONE  = 4'd14;

	typedef logic [1:0] eng_t;
	localparam eng_t ENG_NONE = 2'd0;
	localparam eng_t ENG_A    = 2'd1;
	localparam eng_t ENG_B    = 2'd2;

	typedef logic [1:0] bus_t;
	localparam bus_t BUS_INSTR = 2'd0;
	localparam bus_t BUS_DATA  = 2'd1;
	localparam bus_t BUS_SYS   = 2'd2;

	typedef logic [1:0] src_t;
	localparam src_t SRC_DIRECT = 2'd0;
	localparam src_t SRC_ITCM   = 2'd1;
	localparam src_t SRC_DTCM   = 2'd2;
	localparam src_t SRC_MAIN   = 2'd3;

	typedef logic [7:0] region_t;
	localparam region_t RGN_MAIN  = 8'h02;
	localparam region_t RGN_SWRAM = 8'h03;
	localparam region_t RGN_IO    = 8'h04;
	localparam region_t RGN_PAL   = 8'h05;
	localparam region_t RGN_VRAM  = 8'h06;
	localparam region_t RGN_OAM   = 8'h07;
	localparam region_t RGN_CART  = 8'h08;
	localparam region_t RGN_BIOS  = 8'hFF;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ITCM_BASE    = 3'd0;
	localparam cfg_idx_t CFG_ITCM_LIMIT   = 3'd1;
	localparam cfg_idx_t CFG_DTCM_BASE    = 3'd2;
	localparam cfg_idx_t CFG_DTCM_LIMIT   = 3'd3;
	localparam cfg_idx_t CFG_TCM_ENABLES  = 3'd4;
	localparam cfg_idx_t CFG_SWRAM_MAPPED = 3'd5;
	localparam cfg_idx_t CFG_SWRAM_MASK   = 3'd6;

endpackage

`default_nettype wire

// ===== design/tcm_window_address_decoder.sv =====
// Each transfer's result is valid once it has passed through all four registered stages.
// Throughput: one transfer per cycle; each stage advances when the next has room,
// so the input stalls only while all four stages hold transfers and out_ready is low.
// Reset (arst_n low) clears all configuration registers to 0 and empties the pipe.
// ----------------------------------------------------------------------------
// tcm_window_address_decoder
// Decodes one bus access into target, byte offset and renderer notify range.
// Stage 1 window compare, stage 2 region decode and reciprocal multiply,
// stage 3 quotient back-multiply, stage 4 remainder fix-up and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_window_address_decoder
	import twad_pkg::*;
#(
	parameter int unsigned ITCM_BYTES     = ITCM_BYTES_DFLT,
	parameter int unsigned DTCM_BYTES     = DTCM_BYTES_DFLT,
	parameter int unsigned MAIN_RAM_BYTES = MAIN_RAM_BYTES_DFLT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,

	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        address,
	input  wire logic               is_write,
	input  wire logic [1:0]         bus_kind,
	input  wire logic [1:0]         access_size,
	input  wire logic [63:0]        write_data,

	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              target,
	output logic [21:0]             offset,
	output logic [1:0]              notify_engine,
	output logic [20:0]             notify_lo,
	output logic [21:0]             notify_hi,
	output logic [63:0]             data_out
);

	// Modulo by constant: q = (x * M) >> (32 + L), off by at most one, fixed in stage 4.
	localparam int unsigned IL = $clog2(ITCM_BYTES);
	localparam int unsigned DL = $clog2(DTCM_BYTES);
	localparam int unsigned ML = $clog2(MAIN_RAM_BYTES);

	localparam logic [63:0] ITCM_M64 = (64'd1 << (32 + IL)) / 64'(ITCM_BYTES);
	localparam logic [63:0] DTCM_M64 = (64'd1 << (32 + DL)) / 64'(DTCM_BYTES);
	localparam logic [63:0] MAIN_M64 = (64'd1 << (32 + ML)) / 64'(MAIN_RAM_BYTES);
	localparam logic [32:0] ITCM_M   = ITCM_M64[32:0];
	localparam logic [32:0] DTCM_M   = DTCM_M64[32:0];
	localparam logic [32:0] MAIN_M   = MAIN_M64[32:0];

	localparam logic [IL:0] ITCM_C = (IL + 1)'(ITCM_BYTES);
	localparam logic [DL:0] DTCM_C = (DL + 1)'(DTCM_BYTES);
	localparam logic [ML:0] MAIN_C = (ML + 1)'(MAIN_RAM_BYTES);

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	logic [31:0] itcm_base_q, itcm_limit_q, dtcm_base_q, dtcm_limit_q;
	logic [3:0]  tcm_enables_q;
	logic        swram_mapped_q;
	logic [15:0] swram_mask_q;
	cfg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itcm_base_q    <= '0;
			itcm_limit_q   <= '0;
			dtcm_base_q    <= '0;
			dtcm_limit_q   <= '0;
			tcm_enables_q  <= '0;
			swram_mapped_q <= 1'b0;
			swram_mask_q   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				CFG_ITCM_BASE:    itcm_base_q    <= pwdata;
				CFG_ITCM_LIMIT:   itcm_limit_q   <= pwdata;
				CFG_DTCM_BASE:    dtcm_base_q    <= pwdata;
				CFG_DTCM_LIMIT:   dtcm_limit_q   <= pwdata;
				CFG_TCM_ENABLES:  tcm_enables_q  <= pwdata[3:0];
				CFG_SWRAM_MAPPED: swram_mapped_q <= pwdata[0];
				CFG_SWRAM_MASK:   swram_mask_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			CFG_ITCM_BASE:    prdata = itcm_base_q;
			CFG_ITCM_LIMIT:   prdata = itcm_limit_q;
			CFG_DTCM_BASE:    prdata = dtcm_base_q;
			CFG_DTCM_LIMIT:   prdata = dtcm_limit_q;
			CFG_TCM_ENABLES:  prdata = {28'd0, tcm_enables_q};
			CFG_SWRAM_MAPPED: prdata = {31'd0, swram_mapped_q};
			CFG_SWRAM_MASK:   prdata = {16'd0, swram_mask_q};
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: TCM window compare and base subtract
	// ------------------------------------------------------------------
	logic in_itcm, in_dtcm, bus_sys, bus_data, hit_i, hit_d;

	assign in_itcm  = (address >= itcm_base_q) && (address <= itcm_limit_q);
	assign in_dtcm  = (address >= dtcm_base_q) && (address <= dtcm_limit_q);
	assign bus_sys  = (bus_kind == BUS_SYS);
	assign bus_data = (bus_kind == BUS_DATA);

	always_comb begin
		if (!is_write) begin
			hit_i = tcm_enables_q[0] && !bus_sys && in_itcm;
			hit_d = !hit_i && tcm_enables_q[2] && bus_data && in_dtcm;
		end else begin
			hit_i = !bus_sys && tcm_enables_q[1] && in_itcm;
			hit_d = !hit_i && !bus_sys && tcm_enables_q[3] && in_dtcm;
		end
	end

	logic [31:0] addr_s1, diff_i_s1, diff_d_s1;
	logic        wr_s1, hit_i_s1, hit_d_s1;
	logic [3:0]  size_s1;
	logic [63:0] data_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			addr_s1   <= address;
			wr_s1     <= is_write;
			size_s1   <= 4'd1 << access_size;
			data_s1   <= is_write ? write_data : 64'd0;
			hit_i_s1  <= hit_i;
			hit_d_s1  <= hit_d;
			diff_i_s1 <= address - itcm_base_q;
			diff_d_s1 <= address - dtcm_base_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: region decode, reciprocal multiply
	// ------------------------------------------------------------------
	tgt_t        tgt_c;
	src_t        src_c;
	eng_t        eng_c;
	logic [21:0] off_c, nhi_c;
	logic [20:0] nlo_c;

	always_comb begin
		tgt_c = TGT_NONE;
		src_c = SRC_DIRECT;
		off_c = '0;
		eng_c = ENG_NONE;
		nlo_c = '0;
		nhi_c = '0;
		if (hit_i_s1) begin
			tgt_c = TGT_ITCM;
			src_c = SRC_ITCM;
		end else if (hit_d_s1) begin
			tgt_c = TGT_DTCM;
			src_c = SRC_DTCM;
		end else begin
			unique case (addr_s1[31:24]) inside
				RGN_MAIN: begin
					tgt_c = TGT_MAIN;
					src_c = SRC_MAIN;
				end
				RGN_SWRAM: begin
					if (swram_mapped_q) begin
						tgt_c = TGT_SWRAM;
						off_c = {6'd0, addr_s1[15:0] & swram_mask_q};
					end
				end
				RGN_IO: begin
					tgt_c = TGT_IO;
					off_c = addr_s1[21:0];
				end
				RGN_PAL, RGN_OAM: begin
					tgt_c = addr_s1[25] ? TGT_OAM : TGT_PAL;
					off_c = {11'd0, addr_s1[10:0]};
					if (wr_s1) begin
						eng_c = addr_s1[10] ? ENG_B : ENG_A;
						nlo_c = {11'd0, addr_s1[9:0]};
						nhi_c = {12'd0, addr_s1[9:0]} + {18'd0, size_s1};
					end
				end
				RGN_VRAM: begin
					if (!addr_s1[23]) begin
						tgt_c = TGT_BGA + {2'd0, addr_s1[22:21]};
						off_c = {1'b0, addr_s1[20:0]};
						eng_c = addr_s1[21] ? ENG_B : ENG_A;
					end else begin
						tgt_c = TGT_LCDC;
						off_c = {2'd0, addr_s1[19:0]};
						eng_c = ENG_A;
					end
					if (wr_s1) begin
						nlo_c = off_c[20:0];
						nhi_c = off_c + {18'd0, size_s1};
					end else begin
						eng_c = ENG_NONE;
					end
				end
				RGN_CART: begin
					tgt_c = TGT_CART;
					off_c = addr_s1[21:0];
				end
				RGN_BIOS: begin
					if (!wr_s1 && (addr_s1[31:16] == 16'hFFFF)) begin
						tgt_c = TGT_BIOS;
						off_c = {7'd0, addr_s1[14:0]};
					end
				end
				default: ;
			endcase
		end
	end

	logic [64:0] prod_i, prod_d, prod_m;

	assign prod_i = 65'(diff_i_s1) * 65'(ITCM_M);
	assign prod_d = 65'(diff_d_s1) * 65'(DTCM_M);
	assign prod_m = 65'(addr_s1) * 65'(MAIN_M);

	tgt_t        tgt_s2;
	src_t        src_s2;
	eng_t        eng_s2;
	logic [21:0] off_s2, nhi_s2;
	logic [20:0] nlo_s2;
	logic [63:0] data_s2;
	logic [31:0] q_i_s2, q_d_s2, q_m_s2;
	logic [IL:0] x_i_s2;
	logic [DL:0] x_d_s2;
	logic [ML:0] x_m_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tgt_s2  <= tgt_c;
			src_s2  <= src_c;
			eng_s2  <= eng_c;
			off_s2  <= off_c;
			nlo_s2  <= nlo_c;
			nhi_s2  <= nhi_c;
			data_s2 <= data_s1;
			q_i_s2  <= 32'(prod_i >> (32 + IL));
			q_d_s2  <= 32'(prod_d >> (32 + DL));
			q_m_s2  <= 32'(prod_m >> (32 + ML));
			x_i_s2  <= diff_i_s1[IL:0];
			x_d_s2  <= diff_d_s1[DL:0];
			x_m_s2  <= addr_s1[ML:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: quotient times divisor, low bits only
	// ------------------------------------------------------------------
	tgt_t        tgt_s3;
	src_t        src_s3;
	eng_t        eng_s3;
	logic [21:0] off_s3, nhi_s3;
	logic [20:0] nlo_s3;
	logic [63:0] data_s3;
	logic [IL:0] x_i_s3, rp_i_s3;
	logic [DL:0] x_d_s3, rp_d_s3;
	logic [ML:0] x_m_s3, rp_m_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			tgt_s3  <= tgt_s2;
			src_s3  <= src_s2;
			eng_s3  <= eng_s2;
			off_s3  <= off_s2;
			nlo_s3  <= nlo_s2;
			nhi_s3  <= nhi_s2;
			data_s3 <= data_s2;
			x_i_s3  <= x_i_s2;
			x_d_s3  <= x_d_s2;
			x_m_s3  <= x_m_s2;
			rp_i_s3 <= (IL + 1)'(q_i_s2[IL:0] * ITCM_C);
			rp_d_s3 <= (DL + 1)'(q_d_s2[DL:0] * DTCM_C);
			rp_m_s3 <= (ML + 1)'(q_m_s2[ML:0] * MAIN_C);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: remainder correction, offset select, output register
	// ------------------------------------------------------------------
	logic [IL:0] r_i, r_i_fix;
	logic [DL:0] r_d, r_d_fix;
	logic [ML:0] r_m, r_m_fix;
	logic [21:0] off_fin;

	assign r_i     = x_i_s3 - rp_i_s3;
	assign r_d     = x_d_s3 - rp_d_s3;
	assign r_m     = x_m_s3 - rp_m_s3;
	assign r_i_fix = (r_i >= ITCM_C) ? r_i - ITCM_C : r_i;
	assign r_d_fix = (r_d >= DTCM_C) ? r_d - DTCM_C : r_d;
	assign r_m_fix = (r_m >= MAIN_C) ? r_m - MAIN_C : r_m;

	always_comb begin
		case (src_s3)
			SRC_ITCM: off_fin = 22'(r_i_fix);
			SRC_DTCM: off_fin = 22'(r_d_fix);
			SRC_MAIN: off_fin = 22'(r_m_fix);
			default:  off_fin = off_s3;
		endcase
	end

	tgt_t        tgt_s4;
	eng_t        eng_s4;
	logic [21:0] off_s4, nhi_s4;
	logic [20:0] nlo_s4;
	logic [63:0] data_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			tgt_s4  <= tgt_s3;
			off_s4  <= off_fin;
			eng_s4  <= eng_s3;
			nlo_s4  <= nlo_s3;
			nhi_s4  <= nhi_s3;
			data_s4 <= data_s3;
		end
	end

	assign out_valid     = valid_s4;
	assign target        = tgt_s4;
	assign offset        = off_s4;
	assign notify_engine = eng_s4;
	assign notify_lo     = nlo_s4;
	assign notify_hi     = nhi_s4;
	assign data_out      = data_s4;

endmodule

`default_nettype wire

// ===== design/twad_checker.sv =====
// ----------------------------------------------------------------------------
// twad_checker
// Port-level checks on the decoder result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twad_checker
	import twad_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  target,
	input wire logic [21:0] offset,
	input wire logic [1:0]  notify_engine,
	input wire logic [20:0] notify_lo,
	input wire logic [21:0] notify_hi,
	input wire logic [63:0] data_out
);

	logic        notify_on;
	logic        notify_tgt_ok;
	logic [21:0] notify_span;
	logic        notify_span_ok;

	assign notify_on      = out_valid && (notify_engine != ENG_NONE);
	assign notify_tgt_ok  = (target == TGT_PAL) || (target == TGT_OAM) ||
		(target == TGT_BGA) || (target == TGT_BGB) || (target == TGT_OBJA) ||
		(target == TGT_OBJB) || (target == TGT_LCDC);
	assign notify_span    = notify_hi - 22'(notify_lo);
	assign notify_span_ok = (notify_hi > 22'(notify_lo)) && (notify_span <= 22'd8);

	// notify only for renderer-visible memories
	`TWAD_ASSERT_IMP(a_notify_target, notify_on, notify_tgt_ok)

	// range covers one access of at most eight bytes
	`TWAD_ASSERT_IMP(a_notify_range, notify_on, notify_span_ok)

	// BIOS is read-only: no write data, no notify
	`TWAD_ASSERT_IMP(a_bios_read, out_valid && (target == TGT_BIOS), (data_out == '0) && !notify_on)

	`TWAD_ASSERT_IMP(a_unmapped_off, out_valid && (target == TGT_NONE), offset == 22'd0)

	`TWAD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(target) && $stable(offset))

endmodule

bind tcm_window_address_decoder twad_checker u_twad_checker (.*);

`default_nettype wire

// ===== sim/tcm_window_address_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_window_address_decoder_tb
// Drives bus accesses through the decoder under a series of window and
// switchable RAM settings and checks every decoded transfer field by field against a
// behavioral decode or a directed table row, with random idle and stall on both channels.
// ----------------------------------------------------------------------------

module tcm_window_address_decoder_tb;
	import twad_pkg::*;

	localparam logic [1:0] SZ_BYTE   = 2'd0;
	localparam logic [1:0] SZ_HALF   = 2'd1;
	localparam logic [1:0] SZ_WORD   = 2'd2;
	localparam logic [1:0] SZ_DOUBLE = 2'd3;

	localparam logic [3:0] EN_ITCM_RD = 4'b0001;
	localparam logic [3:0] EN_ITCM_WR = 4'b0010;
	localparam logic [3:0] EN_DTCM_RD = 4'b0100;
	localparam logic [3:0] EN_DTCM_WR = 4'b1000;

	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int DIRECTED_ROWS   = 25;

	typedef struct packed {
		logic [31:0] address;
		logic        is_write;
		bus_t        bus;
		logic [1:0]  size;
		logic [63:0] wdata;
	} access_t;

	typedef struct packed {
		tgt_t        target;
		logic [21:0] offset;
		eng_t        engine;
		logic [20:0] lo;
		logic [21:0] hi;
		logic [63:0] data;
	} decoded_t;

	typedef struct packed {
		access_t  acc;
		logic     given;
		decoded_t want;
	} step_t;

	// Directed rows run with itcm 0x01000000..0x0100FFFF, dtcm 0x027C0000..0x027C3FFF,
	// all TCM enables on and switchable RAM not mapped.
	localparam step_t STEPS [DIRECTED_ROWS] = '{
		'{'{32'h0100_0000, 1'b0, BUS_INSTR, SZ_BYTE, 64'h0}, 1'b1,
			'{TGT_ITCM, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h0100_8004, 1'b0, BUS_DATA, SZ_WORD, 64'h0}, 1'b1,
			'{TGT_ITCM, 22'h4, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h0100_0010, 1'b0, BUS_SYS, SZ_WORD, 64'h0}, 1'b1,
			'{TGT_NONE, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h027C_0010, 1'b0, BUS_DATA, SZ_HALF, 64'h0}, 1'b1,
			'{TGT_DTCM, 22'h10, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h027C_0010, 1'b0, BUS_INSTR, SZ_HALF, 64'h0}, 1'b1,
			'{TGT_MAIN, 22'h3C_0010, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h027C_3FFF, 1'b1, BUS_INSTR, SZ_DOUBLE, 64'h0123_4567_89AB_CDEF}, 1'b1,
			'{TGT_DTCM, 22'h3FFF, ENG_NONE, 21'h0, 22'h0, 64'h0123_4567_89AB_CDEF}},
		'{'{32'h0100_FFFF, 1'b1, 2'd3, SZ_BYTE, 64'hFEDC_BA98_7654_3210}, 1'b1,
			'{TGT_ITCM, 22'h7FFF, ENG_NONE, 21'h0, 22'h0, 64'hFEDC_BA98_7654_3210}},
		'{'{32'h027C_0000, 1'b1, BUS_SYS, SZ_WORD, 64'h5555_AAAA_5555_AAAA}, 1'b0, '0},
		'{'{32'h0300_1234, 1'b0, BUS_DATA, SZ_WORD, 64'h0}, 1'b1,
			'{TGT_NONE, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h04FF_FFFF, 1'b0, BUS_DATA, SZ_BYTE, 64'h0}, 1'b1,
			'{TGT_IO, 22'h3F_FFFF, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h0500_03FE, 1'b1, BUS_DATA, SZ_HALF, 64'h0000_0000_0000_7FFF}, 1'b0, '0},
		'{'{32'h0700_07FC, 1'b1, BUS_INSTR, SZ_WORD, 64'hDEAD_BEEF_0BAD_F00D}, 1'b0, '0},
		'{'{32'h0500_0400, 1'b0, BUS_DATA, SZ_HALF, 64'h0}, 1'b1,
			'{TGT_PAL, 22'h400, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h0600_0000, 1'b1, BUS_DATA, SZ_BYTE, 64'h0000_0000_0000_00A5}, 1'b0, '0},
		'{'{32'h0621_FFFF, 1'b1, BUS_SYS, SZ_DOUBLE, 64'hFFFF_0000_FFFF_0000}, 1'b0, '0},
		'{'{32'h0640_1000, 1'b1, BUS_DATA, SZ_WORD, 64'h1357_9BDF_2468_ACE0}, 1'b0, '0},
		'{'{32'h0670_0002, 1'b1, 2'd3, SZ_HALF, 64'h0000_0000_0000_C0DE}, 1'b0, '0},
		'{'{32'h068F_FFFF, 1'b1, BUS_DATA, SZ_DOUBLE, 64'h8888_7777_6666_5555}, 1'b0, '0},
		'{'{32'h06F0_0000, 1'b0, BUS_DATA, SZ_WORD, 64'h0}, 1'b1,
			'{TGT_LCDC, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h08AB_CDEF, 1'b0, BUS_DATA, SZ_BYTE, 64'h0}, 1'b1,
			'{TGT_CART, 22'h2B_CDEF, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'hFFFF_FFFF, 1'b0, BUS_SYS, SZ_BYTE, 64'h0}, 1'b1,
			'{TGT_BIOS, 22'h7FFF, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'hFFFF_0000, 1'b1, BUS_DATA, SZ_WORD, 64'h8000_0000_0000_0001}, 1'b1,
			'{TGT_NONE, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h8000_0000_0000_0001}},
		'{'{32'hFF00_0000, 1'b0, BUS_INSTR, SZ_WORD, 64'h0}, 1'b1,
			'{TGT_NONE, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'h0000_0000, 1'b0, BUS_INSTR, SZ_DOUBLE, 64'h0}, 1'b1,
			'{TGT_NONE, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'h0}},
		'{'{32'hFFFF_FFFF, 1'b1, 2'd3, SZ_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
			'{TGT_NONE, 22'h0, ENG_NONE, 21'h0, 22'h0, 64'hFFFF_FFFF_FFFF_FFFF}}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        address = '0;
	logic               is_write = 1'b0;
	logic [1:0]         bus_kind = '0;
	logic [1:0]         access_size = '0;
	logic [63:0]        write_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [3:0]         target;
	logic [21:0]        offset;
	logic [1:0]         notify_engine;
	logic [20:0]        notify_lo;
	logic [21:0]        notify_hi;
	logic [63:0]        data_out;

	logic [31:0] itcm_base_q, itcm_limit_q, dtcm_base_q, dtcm_limit_q;
	logic [3:0]  tcm_en_q;
	logic        swram_on_q;
	logic [15:0] swram_mask_q;

	decoded_t pending_decodes [$];
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	tcm_window_address_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .address(address),
		.is_write(is_write), .bus_kind(bus_kind), .access_size(access_size),
		.write_data(write_data),
		.out_valid(out_valid), .out_ready(out_ready), .target(target),
		.offset(offset), .notify_engine(notify_engine), .notify_lo(notify_lo),
		.notify_hi(notify_hi), .data_out(data_out)
	);

	always #5 clk = ~clk;

	function automatic decoded_t decode_access(access_t a);
		decoded_t    d;
		logic        hit;
		logic [31:0] span;
		logic [3:0]  sub;
		logic [3:0]  nbytes;
		d = '0;
		d.target = TGT_NONE;
		hit = 1'b0;
		nbytes = 4'd1 << a.size;
		if (!a.is_write) begin
			if (tcm_en_q[0] && a.bus != BUS_SYS && a.address >= itcm_base_q &&
					a.address <= itcm_limit_q) begin
				d.target = TGT_ITCM;
				span = a.address - itcm_base_q;
				d.offset = 22'(span % ITCM_BYTES_DFLT);
				hit = 1'b1;
			end else if (tcm_en_q[2] && a.bus == BUS_DATA && a.address >= dtcm_base_q &&
					a.address <= dtcm_limit_q) begin
				d.target = TGT_DTCM;
				span = a.address - dtcm_base_q;
				d.offset = 22'(span % DTCM_BYTES_DFLT);
				hit = 1'b1;
			end
		end else if (a.bus != BUS_SYS) begin
			if (tcm_en_q[1] && a.address >= itcm_base_q && a.address <= itcm_limit_q) begin
				d.target = TGT_ITCM;
				span = a.address - itcm_base_q;
				d.offset = 22'(span % ITCM_BYTES_DFLT);
				hit = 1'b1;
			end else if (tcm_en_q[3] && a.address >= dtcm_base_q &&
					a.address <= dtcm_limit_q) begin
				d.target = TGT_DTCM;
				span = a.address - dtcm_base_q;
				d.offset = 22'(span % DTCM_BYTES_DFLT);
				hit = 1'b1;
			end
		end
		if (!hit) begin
			case (a.address[31:24]) inside
				RGN_MAIN: begin
					d.target = TGT_MAIN;
					d.offset = 22'(a.address % MAIN_RAM_BYTES_DFLT);
				end
				RGN_SWRAM: begin
					if (swram_on_q) begin
						d.target = TGT_SWRAM;
						d.offset = {6'd0, a.address[15:0] & swram_mask_q};
					end
				end
				RGN_IO: begin
					d.target = TGT_IO;
					d.offset = a.address[21:0];
				end
				RGN_PAL, RGN_OAM: begin
					d.target = (a.address[31:24] == RGN_PAL) ? TGT_PAL : TGT_OAM;
					d.offset = {11'd0, a.address[10:0]};
					if (a.is_write) begin
						d.engine = a.address[10] ? ENG_B : ENG_A;
						d.lo = {11'd0, a.address[9:0]};
						d.hi = {1'b0, d.lo} + nbytes;
					end
				end
				RGN_VRAM: begin
					sub = a.address[23:20];
					if (!sub[3]) begin
						case (sub[2:1])
							2'd0: d.target = TGT_BGA;
							2'd1: d.target = TGT_BGB;
							2'd2: d.target = TGT_OBJA;
							default: d.target = TGT_OBJB;
						endcase
						d.offset = {1'b0, a.address[20:0]};
						d.engine = sub[1] ? ENG_B : ENG_A;
					end else begin
						d.target = TGT_LCDC;
						d.offset = {2'd0, a.address[19:0]};
						d.engine = ENG_A;
					end
					if (a.is_write) begin
						d.lo = d.offset[20:0];
						d.hi = d.offset + nbytes;
					end else begin
						d.engine = ENG_NONE;
					end
				end
				RGN_CART: begin
					d.target = TGT_CART;
					d.offset = a.address[21:0];
				end
				RGN_BIOS: begin
					if (!a.is_write && a.address[23:16] == 8'hFF) begin
						d.target = TGT_BIOS;
						d.offset = {7'd0, a.address[14:0]};
					end
				end
				default: ;
			endcase
		end
		d.data = a.is_write ? a.wdata : 64'd0;
		return d;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_side
		decoded_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_decodes.size() == 0) begin
				note_mismatch("unexpected transfer target", 64'(target), 64'(TGT_NONE));
			end else begin
				want = pending_decodes.pop_front();
				if (target !== want.target)
					note_mismatch("target", 64'(target), 64'(want.target));
				if (offset !== want.offset)
					note_mismatch("offset", 64'(offset), 64'(want.offset));
				if (notify_engine !== want.engine)
					note_mismatch("notify_engine", 64'(notify_engine), 64'(want.engine));
				if (notify_lo !== want.lo)
					note_mismatch("notify_lo", 64'(notify_lo), 64'(want.lo));
				if (notify_hi !== want.hi)
					note_mismatch("notify_hi", 64'(notify_hi), 64'(want.hi));
				if (data_out !== want.data)
					note_mismatch("data_out", data_out, want.data);
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic reg_write(cfg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_ITCM_BASE:    itcm_base_q = val;
			CFG_ITCM_LIMIT:   itcm_limit_q = val;
			CFG_DTCM_BASE:    dtcm_base_q = val;
			CFG_DTCM_LIMIT:   dtcm_limit_q = val;
			CFG_TCM_ENABLES:  tcm_en_q = val[3:0];
			CFG_SWRAM_MAPPED: swram_on_q = val[0];
			CFG_SWRAM_MASK:   swram_mask_q = val[15:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [31:0] ib, logic [31:0] il, logic [31:0] db,
			logic [31:0] dl, logic [3:0] en, logic sw, logic [15:0] mask);
		reg_write(CFG_ITCM_BASE, ib);
		reg_write(CFG_ITCM_LIMIT, il);
		reg_write(CFG_DTCM_BASE, db);
		reg_write(CFG_DTCM_LIMIT, dl);
		reg_write(CFG_TCM_ENABLES, {28'd0, en});
		reg_write(CFG_SWRAM_MAPPED, {31'd0, sw});
		reg_write(CFG_SWRAM_MASK, {16'd0, mask});
	endtask

	function automatic logic [7:0] pick_region();
		case ($urandom_range(0, 11))
			0: return RGN_MAIN;
			1: return RGN_SWRAM;
			2: return RGN_IO;
			3: return RGN_PAL;
			4: return RGN_VRAM;
			5: return RGN_OAM;
			6: return RGN_CART;
			7: return RGN_BIOS;
			8: return 8'h00;
			9: return 8'h01;
			10: return 8'h09;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic access_t random_access();
		access_t a;
		a.is_write = 1'($urandom);
		a.bus = bus_t'($urandom_range(0, 3));
		a.size = 2'($urandom_range(0, 3));
		a.wdata = {$urandom, $urandom};
		case ($urandom_range(0, 15)) inside
			0, 1: a.address = $urandom;
			2, 3: a.address = ($urandom_range(0, 1) ? itcm_base_q : itcm_limit_q)
				+ 32'($urandom_range(0, 16)) - 32'd8;
			4, 5: a.address = ($urandom_range(0, 1) ? dtcm_base_q : dtcm_limit_q)
				+ 32'($urandom_range(0, 16)) - 32'd8;
			6: a.address = itcm_base_q + 32'($urandom_range(0, 32'h1_0000));
			7: a.address = dtcm_base_q + 32'($urandom_range(0, 32'h8000));
			default: begin
				a.address = {pick_region(), 24'($urandom)};
				if (a.address[31:24] == RGN_BIOS && $urandom_range(0, 1))
					a.address[23:16] = 8'hFF;
			end
		endcase
		return a;
	endfunction

	task automatic random_windows();
		logic [31:0] ib, db;
		ib = {pick_region(), 24'($urandom)};
		db = $urandom_range(0, 2) == 0 ? ib + 32'($urandom_range(0, 32'h4000))
			: {pick_region(), 24'($urandom)};
		program_all(ib,
			$urandom_range(0, 4) == 0 ? $urandom : ib + 32'($urandom_range(0, 32'h2_0000)),
			db,
			$urandom_range(0, 4) == 0 ? $urandom : db + 32'($urandom_range(0, 32'h1_0000)),
			4'($urandom_range(0, 15)), 1'($urandom), 16'($urandom));
	endtask

	task automatic push_access(access_t acc, logic given, decoded_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		address <= acc.address;
		is_write <= acc.is_write;
		bus_kind <= acc.bus;
		access_size <= acc.size;
		write_data <= acc.wdata;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_decodes.push_back(given ? want : decode_access(acc));
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
			default: begin send_idle_pct = 13; recv_stall_pct = 13; end
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_decodes.size() != 0) @(posedge clk);
	endtask

	initial begin
		itcm_base_q = '0;
		itcm_limit_q = '0;
		dtcm_base_q = '0;
		dtcm_limit_q = '0;
		tcm_en_q = '0;
		swram_on_q = 1'b0;
		swram_mask_q = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_idling(p);
			case (p)
				0: ;
				1: begin
					program_all(32'h0100_0000, 32'h0100_FFFF, 32'h027C_0000, 32'h027C_3FFF,
						EN_ITCM_RD | EN_ITCM_WR | EN_DTCM_RD | EN_DTCM_WR, 1'b0, 16'h7FFF);
					set_idling(3);
					for (int i = 0; i < DIRECTED_ROWS; i++)
						push_access(STEPS[i].acc, STEPS[i].given, STEPS[i].want);
					drain();
					set_idling(p);
				end
				2: program_all(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
					EN_ITCM_RD | EN_DTCM_RD, 1'b1, 16'hFFFF);
				3: program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
					EN_ITCM_WR | EN_DTCM_WR, 1'b1, 16'h0000);
				default: random_windows();
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				push_access(random_access(), 1'b0, '0);
			drain();
		end

		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/twad_pkg.sv
design/tcm_window_address_decoder.sv
design/twad_checker.sv
sim/tcm_window_address_decoder_tb.sv
